### hdl/dag_pkg.sv
// Shared types, constants and constant functions of the distance attenuation gain block.
`default_nettype none
package dag_pkg;

	// Default resolution of the logarithm, in fraction bits
	localparam int LOG_TABLE_BITS = 8;

	// Register indexes of the write port
	localparam logic [1:0] CFG_REF_DIST  = 2'd0;
	localparam logic [1:0] CFG_ATT       = 2'd1;
	localparam logic [1:0] CFG_EXTRA     = 2'd2;
	localparam logic [1:0] CFG_MIN_DIST  = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ERR    = 2'd1;
	localparam logic [1:0] ST_BYPASS = 2'd2;
	localparam logic [1:0] ST_SAT    = 2'd3;

	localparam logic [31:0] GAIN_ONE = 32'h0100_0000;
	localparam logic [31:0] GAIN_MAX = 32'hFFFF_FFFF;

	// round(2^24 / 6.0206)
	localparam logic [21:0] INV_DB_PER_OCTAVE = 22'd2786635;

	// Control that travels with each item
	typedef struct packed {
		logic       vld;
		logic       early;  // result already decided, gain is a fixed value
		logic [1:0] st;
	} ctrl_t;

	// Bitwise integer square root, used at elaboration only
	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v   = v_in;
		res = '0;
		for (int i = 31; i >= 0; i--) begin
			b = 64'd1 << (2 * i);
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
		end
		return res;
	endfunction

	// 2^(2^-k) in Q2.30, built by k truncated square roots of 2
	function automatic logic [31:0] root_const(input int k);
		logic [63:0] r;
		r = 64'd2 << 30;
		for (int i = 1; i <= k; i++) begin
			r = isqrt64(r << 30);
		end
		return r[31:0];
	endfunction

endpackage
`default_nettype wire

### hdl/dag_log2.sv
// Pipelined log2 of an unsigned Q16.16 value by repeated squaring.
`default_nettype none
module dag_log2 #(
	parameter int LTB = dag_pkg::LOG_TABLE_BITS
) (
	input  wire logic               clk,
	input  wire logic [31:0]        x,
	output logic signed [21:0]      logv
);

	logic [31:0]    m_s    [0:LTB];
	logic [4:0]     e_s    [0:LTB];
	logic [LTB-1:0] frac_s [0:LTB];

	logic [4:0]  e_in;
	logic [31:0] m_in;
	logic [5:0]  e_m16;

	// leading one and normalisation
	always_comb begin
		e_in = '0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) e_in = 5'(i);
		end
		m_in = x << (5'd31 - e_in);
	end

	always_ff @(posedge clk) begin
		m_s[0]    <= m_in;
		e_s[0]    <= e_in;
		frac_s[0] <= '0;
	end

	// one fraction bit per stage
	for (genvar k = 0; k < LTB; k++) begin : g_sq
		logic [63:0] sq;
		logic [32:0] sh;
		assign sq = 64'(m_s[k]) * 64'(m_s[k]);
		assign sh = sq[63:31];
		always_ff @(posedge clk) begin
			e_s[k+1] <= e_s[k];
			if (sh[32]) begin
				m_s[k+1]    <= sh[32:1];
				frac_s[k+1] <= {frac_s[k][LTB-2:0], 1'b1};
			end else begin
				m_s[k+1]    <= sh[31:0];
				frac_s[k+1] <= {frac_s[k][LTB-2:0], 1'b0};
			end
		end
	end

	assign e_m16 = {1'b0, e_s[LTB]} - 6'd16;
	assign logv  = $signed({e_m16, frac_s[LTB], {(16-LTB){1'b0}}});

endmodule
`default_nettype wire

### hdl/dag_exp2.sv
// Pipelined 2^f for a 24-bit fraction, one root-of-two multiply per stage, Q2.30 result.
`default_nettype none
module dag_exp2 (
	input  wire logic        clk,
	input  wire logic [23:0] f,
	output logic [31:0]      acc
);

	logic [31:0] acc_s [0:24];
	logic [23:0] f_s   [0:24];

	assign acc_s[0] = 32'd1 << 30;
	assign f_s[0]   = f;

	for (genvar k = 1; k <= 24; k++) begin : g_mul
		localparam logic [31:0] ROOT = dag_pkg::root_const(k);
		logic [63:0] prod;
		assign prod = 64'(acc_s[k-1]) * 64'(ROOT);
		always_ff @(posedge clk) begin
			f_s[k] <= f_s[k-1];
			if (f_s[k-1][24-k]) acc_s[k] <= prod[61:30];
			else                acc_s[k] <= acc_s[k-1];
		end
	end

	assign acc = acc_s[24];

endmodule
`default_nettype wire

### hdl/distance_attenuation_gain.sv
// Top level: distance to linear gain, fully pipelined.
//
// One distance is taken in every cycle (busy is always low) and each gives one result, shown
// with done for a single cycle. Most of the pipeline depth lies in the logarithm (one squaring
// per stage) and the power of two (one multiply per fraction bit).
// The receiver cannot stall; results must be taken as they appear.
`default_nettype none
module distance_attenuation_gain #(
	parameter int LOG_TABLE_BITS = dag_pkg::LOG_TABLE_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] distance,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [31:0] wr_data,
	output logic             done,
	output logic [31:0]      gain,
	output logic [1:0]       status
);

	localparam int LTB = LOG_TABLE_BITS;

	logic [31:0]        ref_dist_q;
	logic signed [15:0] att_q;
	logic signed [15:0] extra_q;
	logic [15:0]        min_dist_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_dist_q <= 32'd65536;
			att_q      <= -16'sd1541;
			extra_q    <= '0;
			min_dist_q <= 16'd66;
		end else if (wr_en) begin
			unique case (wr_index)
				dag_pkg::CFG_REF_DIST: ref_dist_q <= wr_data;
				dag_pkg::CFG_ATT:      att_q      <= $signed(wr_data[15:0]);
				dag_pkg::CFG_EXTRA:    extra_q    <= $signed(wr_data[15:0]);
				dag_pkg::CFG_MIN_DIST: min_dist_q <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// entry classification
	dag_pkg::ctrl_t ctrl_in;
	logic [31:0]    ref_eff;
	always_comb begin
		ctrl_in.vld   = start;
		ctrl_in.early = 1'b0;
		ctrl_in.st    = dag_pkg::ST_OK;
		if (distance == 32'd0 || distance[31]) begin
			ctrl_in.early = 1'b1;
			ctrl_in.st    = dag_pkg::ST_ERR;
		end else if (distance <= {16'd0, min_dist_q} || att_q == 16'sd0) begin
			ctrl_in.early = 1'b1;
			ctrl_in.st    = dag_pkg::ST_BYPASS;
		end
		ref_eff = (ref_dist_q == 32'd0) ? 32'd1 : ref_dist_q;
	end

	logic signed [21:0] log_d;
	logic signed [21:0] log_r;

	dag_log2 #(.LTB(LTB)) u_log_d (.clk(clk), .x(distance), .logv(log_d));
	dag_log2 #(.LTB(LTB)) u_log_r (.clk(clk), .x(ref_eff),  .logv(log_r));

	dag_pkg::ctrl_t ctrl_lg [0:LTB];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LTB; i++) ctrl_lg[i] <= '0;
		end else begin
			ctrl_lg[0] <= ctrl_in;
			for (int i = 1; i <= LTB; i++) ctrl_lg[i] <= ctrl_lg[i-1];
		end
	end

	// exponent in dB: att * (log2 d - log2 ref) + extra
	logic signed [22:0] ldiff;
	logic signed [39:0] t_s1;
	dag_pkg::ctrl_t     ctrl_s1;
	assign ldiff = 23'(log_d) - 23'(log_r);

	always_ff @(posedge clk) begin
		t_s1 <= 40'(att_q * ldiff) + ($signed(40'(extra_q)) <<< 16);
	end

	// scale by 1/6.0206, split into two partial products
	logic signed [42:0] phi_s2;
	logic [41:0]        plo_s2;
	dag_pkg::ctrl_t     ctrl_s2;
	always_ff @(posedge clk) begin
		phi_s2 <= $signed(t_s1[39:20]) * $signed({1'b0, dag_pkg::INV_DB_PER_OCTAVE});
		plo_s2 <= t_s1[19:0] * dag_pkg::INV_DB_PER_OCTAVE;
	end

	// sum, floor shift, saturation test
	logic signed [63:0] ysum;
	logic signed [39:0] y;
	assign ysum = ($signed(64'(phi_s2)) <<< 20) + $signed({22'd0, plo_s2});
	assign y    = ysum[63:24];

	logic [23:0]        f_s3;
	logic signed [15:0] n_s3;
	dag_pkg::ctrl_t     ctrl_s3;
	dag_pkg::ctrl_t     ctrl_s3_d;
	always_ff @(posedge clk) begin
		f_s3 <= y[23:0];
		n_s3 <= y[39:24];
	end

	// gain of 256 or more is settled here
	always_comb begin
		ctrl_s3_d = ctrl_s2;
		if (!ctrl_s2.early && y >= (40'sd8 <<< 24)) begin
			ctrl_s3_d.early = 1'b1;
			ctrl_s3_d.st    = dag_pkg::ST_SAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else begin
			ctrl_s1 <= ctrl_lg[LTB];
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s3_d;
		end
	end

	// power of two of the fraction
	logic [31:0] acc;
	dag_exp2 u_exp2 (.clk(clk), .f(f_s3), .acc(acc));

	dag_pkg::ctrl_t     ctrl_ex [0:23];
	logic signed [15:0] n_ex    [0:23];
	always_ff @(posedge clk) begin
		n_ex[0] <= n_s3;
		for (int i = 1; i < 24; i++) n_ex[i] <= n_ex[i-1];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 24; i++) ctrl_ex[i] <= '0;
		end else begin
			ctrl_ex[0] <= ctrl_s3;
			for (int i = 1; i < 24; i++) ctrl_ex[i] <= ctrl_ex[i-1];
		end
	end

	// integer part: shift Q2.30 into Q8.24
	logic signed [16:0] rsh;
	logic [32:0]        gain_w;
	logic [31:0]        gain_n;
	logic [1:0]         st_n;
	dag_pkg::ctrl_t     cf;
	always_comb begin
		cf     = ctrl_ex[23];
		rsh    = 17'sd6 - 17'(n_ex[23]);
		gain_w = '0;
		if (rsh < 17'sd0)       gain_w = {1'b0, acc} << 6'(-rsh);
		else if (rsh < 17'sd32) gain_w = {1'b0, acc} >> 5'(rsh);
		gain_n = gain_w[31:0];
		st_n   = dag_pkg::ST_OK;
		if (cf.early) begin
			st_n   = cf.st;
			gain_n = (cf.st == dag_pkg::ST_SAT) ? dag_pkg::GAIN_MAX : dag_pkg::GAIN_ONE;
		end else if (gain_w[32]) begin
			st_n   = dag_pkg::ST_SAT;
			gain_n = dag_pkg::GAIN_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cf.vld;
		end
	end

	always_ff @(posedge clk) begin
		gain   <= gain_n;
		status <= st_n;
	end

endmodule
`default_nettype wire

### tb/distance_attenuation_gain_test.sv
// Self-checking testbench of the distance to linear gain block.
`default_nettype none
module distance_attenuation_gain_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Pipeline depth of the block, from start to done
	localparam int PIPE_DEPTH = dag_pkg::LOG_TABLE_BITS + 29;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] distance;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [31:0] wr_data;
	logic        done;
	logic [31:0] gain;
	logic [1:0]  status;

	distance_attenuation_gain u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .distance(distance),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.done(done), .gain(gain), .status(status)
	);

	typedef struct {
		logic [31:0] gain;
		logic [1:0]  status;
	} gain_res_t;

	// Kinds of row in the directed table
	typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  idx;
		logic [31:0] data;
		logic [31:0] exp_gain;
		logic [1:0]  exp_status;
	} stim_row_t;

	// Local copy of the registers
	logic [31:0]        ref_dist_q;
	logic signed [15:0] att_q;
	logic signed [15:0] extra_q;
	logic [15:0]        min_dist_q;

	gain_res_t gain_queue[$];
	int        fail_count;
	int        send_idle_pct;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// Integer square root, bit by bit
	function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v   = v_in;
		res = '0;
		b   = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// log2 of a nonzero Q16.16 value as signed Q16.16, fraction by squaring
	function automatic longint log2_q16(input logic [31:0] x);
		int          e;
		logic [63:0] m;
		longint      frac;
		e    = 31;
		frac = 0;
		while (e > 0 && x[e] == 1'b0) e--;
		m = ({32'd0, x} << (31 - e)) & 64'hFFFF_FFFF;
		for (int k = 0; k < dag_pkg::LOG_TABLE_BITS; k++) begin
			m    = (m * m) >> 31;
			frac = frac * 2;
			if (m >= 64'h1_0000_0000) begin
				frac = frac + 1;
				m    = m >> 1;
			end
		end
		return longint'(e - 16) * 65536
			+ frac * (longint'(1) << (16 - dag_pkg::LOG_TABLE_BITS));
	endfunction

	// Expected gain and status of one distance under the current registers
	function automatic gain_res_t predict_gain(input logic [31:0] d);
		gain_res_t   r;
		logic [31:0] ref_d;
		longint      t;
		longint      y;
		longint      n;
		longint      f;
		logic [63:0] acc;
		logic [63:0] root;
		logic [63:0] g;
		int          sh;
		ref_d = (ref_dist_q == 0) ? 32'd1 : ref_dist_q;
		if (d == 0 || d[31]) begin
			r.gain = dag_pkg::GAIN_ONE; r.status = dag_pkg::ST_ERR;
			return r;
		end
		if (d <= {16'd0, min_dist_q} || att_q == 0) begin
			r.gain = dag_pkg::GAIN_ONE; r.status = dag_pkg::ST_BYPASS;
			return r;
		end
		t = longint'(att_q) * (log2_q16(d) - log2_q16(ref_d)) + longint'(extra_q) * 65536;
		y = (t * longint'(dag_pkg::INV_DB_PER_OCTAVE)) >>> 24;
		if (y >= (longint'(8) << 24)) begin
			r.gain = dag_pkg::GAIN_MAX; r.status = dag_pkg::ST_SAT;
			return r;
		end
		n    = y >>> 24;
		f    = y - (n << 24);
		acc  = 64'd1 << 30;
		root = 64'd2 << 30;
		for (int k = 1; k <= 24; k++) begin
			root = int_sqrt(root << 30);
			if (f[24 - k]) acc = (acc * root) >> 30;
		end
		sh = int'(n - 6);
		if (sh >= 0) g = acc << sh;
		else if (-sh > 40) g = 0;
		else g = acc >> (-sh);
		if (g > 64'hFFFF_FFFF) begin
			r.gain = dag_pkg::GAIN_MAX; r.status = dag_pkg::ST_SAT;
		end else begin
			r.gain = g[31:0]; r.status = dag_pkg::ST_OK;
		end
		return r;
	endfunction

	// Check each result against the oldest expectation
	always @(negedge clk) begin
		gain_res_t want;
		if (arst_n && done) begin
			if (gain_queue.size() == 0) begin
				$display("%0t: unexpected result gain %h status %0d", $realtime, gain, status);
				fail_count++;
			end else begin
				want = gain_queue.pop_front();
				if (gain !== want.gain) begin
					$display("%0t: gain expected %h actual %h", $realtime, want.gain, gain);
					fail_count++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $realtime, want.status,
						status);
					fail_count++;
				end
			end
		end
	end

	// Offer one distance and hold it until taken; start stays high afterwards
	task automatic send_distance(input logic [31:0] d, input logic use_exp,
			input gain_res_t exp_res);
		logic taken;
		start    <= 1'b1;
		distance <= d;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		gain_queue.push_back(use_exp ? exp_res : predict_gain(d));
	endtask

	// Sender gap of a random length, per the current idle rate
	task automatic sender_gap();
		if ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Register write; wr_en is left high for a following write
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		case (idx)
			dag_pkg::CFG_REF_DIST: ref_dist_q = data;
			dag_pkg::CFG_ATT:      att_q      = data[15:0];
			dag_pkg::CFG_EXTRA:    extra_q    = data[15:0];
			default:               min_dist_q = data[15:0];
		endcase
	endtask

	// Quiet the block before registers change
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (gain_queue.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	function automatic logic [15:0] pick16();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(0, 4000)) - 2000);
			default: return 16'($urandom);
		endcase
	endfunction

	// Random register setting, extremes among them
	task automatic random_config();
		logic [31:0] rd;
		case ($urandom_range(4))
			0: rd = 32'd0;
			1: rd = 32'hFFFF_FFFF;
			2: rd = 32'd65536;
			default: rd = $urandom >> $urandom_range(0, 31);
		endcase
		write_reg(dag_pkg::CFG_REF_DIST, rd);
		write_reg(dag_pkg::CFG_ATT, {16'd0, pick16()});
		write_reg(dag_pkg::CFG_EXTRA, {16'd0, ($urandom_range(2) == 0) ? pick16()
			: 16'($signed($urandom_range(0, 6000)) - 3000)});
		write_reg(dag_pkg::CFG_MIN_DIST, {16'd0, ($urandom_range(3) == 0) ? 16'hFFFF
			: 16'($urandom_range(0, 300))});
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Random distance: mostly positive over a wide log range
	function automatic logic [31:0] random_distance();
		case ($urandom_range(9))
			0: return $urandom | 32'h8000_0000;
			1: return 32'($urandom_range(0, 3));
			2: return {16'd0, min_dist_q} + 32'($urandom_range(0, 2)) - 32'd1;
			3: return $urandom;
			default: return ($urandom >> $urandom_range(1, 31)) | 32'd1;
		endcase
	endfunction

	stim_row_t dir_rows[] = '{
		'{ROW_CHECKED, 2'd0, 32'd0,         dag_pkg::GAIN_ONE, dag_pkg::ST_ERR},
		'{ROW_CHECKED, 2'd0, 32'hFFFF_FFFF, dag_pkg::GAIN_ONE, dag_pkg::ST_ERR},
		'{ROW_CHECKED, 2'd0, 32'h8000_0000, dag_pkg::GAIN_ONE, dag_pkg::ST_ERR},
		'{ROW_CHECKED, 2'd0, 32'd66,        dag_pkg::GAIN_ONE, dag_pkg::ST_BYPASS},
		'{ROW_CHECKED, 2'd0, 32'd1,         dag_pkg::GAIN_ONE, dag_pkg::ST_BYPASS},
		'{ROW_CHECKED, 2'd0, 32'd65536,     dag_pkg::GAIN_ONE, dag_pkg::ST_OK},
		'{ROW_ITEM,    2'd0, 32'd67,        '0, dag_pkg::ST_OK},
		'{ROW_ITEM,    2'd0, 32'h7FFF_FFFF, '0, dag_pkg::ST_OK},
		'{ROW_ITEM,    2'd0, 32'h0003_0000, '0, dag_pkg::ST_OK},
		'{ROW_REG,     dag_pkg::CFG_ATT, 32'd0,      '0, dag_pkg::ST_OK},
		'{ROW_CHECKED, 2'd0, 32'd65536,     dag_pkg::GAIN_ONE, dag_pkg::ST_BYPASS},
		'{ROW_REG,     dag_pkg::CFG_ATT, 32'h8000,   '0, dag_pkg::ST_OK},
		'{ROW_REG,     dag_pkg::CFG_EXTRA, 32'h7FFF, '0, dag_pkg::ST_OK},
		'{ROW_REG,     dag_pkg::CFG_MIN_DIST, 32'd0, '0, dag_pkg::ST_OK},
		'{ROW_ITEM,    2'd0, 32'd1,         '0, dag_pkg::ST_OK},
		'{ROW_ITEM,    2'd0, 32'h7FFF_FFFF, '0, dag_pkg::ST_OK},
		'{ROW_REG,     dag_pkg::CFG_REF_DIST, 32'd0, '0, dag_pkg::ST_OK},
		'{ROW_CHECKED, 2'd0, 32'd1,         dag_pkg::GAIN_MAX, dag_pkg::ST_SAT},
		'{ROW_REG,     dag_pkg::CFG_EXTRA, 32'h8000, '0, dag_pkg::ST_OK},
		'{ROW_REG,     dag_pkg::CFG_ATT, 32'h7FFF,   '0, dag_pkg::ST_OK},
		'{ROW_REG,     dag_pkg::CFG_REF_DIST, 32'hFFFF_FFFF, '0, dag_pkg::ST_OK},
		'{ROW_ITEM,    2'd0, 32'd1,         '0, dag_pkg::ST_OK},
		'{ROW_ITEM,    2'd0, 32'h7FFF_FFFF, '0, dag_pkg::ST_OK},
		'{ROW_REG,     dag_pkg::CFG_MIN_DIST, 32'hFFFF, '0, dag_pkg::ST_OK},
		'{ROW_CHECKED, 2'd0, 32'h0000_FFFF, dag_pkg::GAIN_ONE, dag_pkg::ST_BYPASS},
		'{ROW_ITEM,    2'd0, 32'h0001_0000, '0, dag_pkg::ST_OK}
	};

	initial begin
		gain_res_t exp_res;
		logic      in_reg;
		int        phase_idle[4];
		phase_idle    = '{0, 65, 0, 9};
		arst_n        = 1'b0;
		start         = 1'b0;
		distance      = '0;
		wr_en         = 1'b0;
		wr_index      = '0;
		wr_data       = '0;
		fail_count    = 0;
		send_idle_pct = 0;
		ref_dist_q    = 32'd65536;
		att_q         = -16'sd1541;
		extra_q       = '0;
		min_dist_q    = 16'd66;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		in_reg = 1'b0;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG) begin
				if (!in_reg) drain();
				in_reg = 1'b1;
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				if (in_reg) wr_en <= 1'b0;
				in_reg = 1'b0;
				exp_res.gain   = dir_rows[i].exp_gain;
				exp_res.status = dir_rows[i].exp_status;
				send_distance(dir_rows[i].data, dir_rows[i].kind == ROW_CHECKED, exp_res);
			end
		end

		// Random phases, registers changed between them
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			if (ph == 0) begin
				write_reg(dag_pkg::CFG_REF_DIST, 32'd65536);
				write_reg(dag_pkg::CFG_ATT, 32'h0000_F9FB);
				write_reg(dag_pkg::CFG_EXTRA, 32'd0);
				write_reg(dag_pkg::CFG_MIN_DIST, 32'd66);
				wr_en <= 1'b0;
				@(posedge clk);
			end else begin
				random_config();
			end
			send_idle_pct = phase_idle[ph % 4];
			for (int n = 0; n < 172; n++) begin
				send_distance(random_distance(), 1'b0, exp_res);
				if (ph == 1 && n == 80) begin
					start <= 1'b0;
					@(posedge clk);
					while (gain_queue.size() != 0) @(posedge clk);
				end else begin
					sender_gap();
				end
			end
		end

		start <= 1'b0;
		while (gain_queue.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

### files.f
hdl/dag_pkg.sv
hdl/dag_log2.sv
hdl/dag_exp2.sv
hdl/distance_attenuation_gain.sv
tb/distance_attenuation_gain_test.sv
